// ===== rtl/am_sg_pkg.sv =====
// Shared types, constants and the cosine table function for the AM tone generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package am_sg_pkg;

	// Field and register widths
	localparam int PHASE_W    = 32;
	localparam int DEPTH_W    = 16;
	localparam int SC_W       = 21;
	localparam int COS_W      = 16;
	localparam int SAMPLE_W   = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Defaults for the top level parameters
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int COUNT_BITS_DEF      = 20;

	// Register reset values
	localparam logic [DEPTH_W-1:0] DEPTH_RESET        = 16'd16384;
	localparam logic [SC_W-1:0]    SAMPLE_COUNT_RESET = 21'd1024;

	// Output saturation bounds, Q2.14
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 17'sd32768;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -17'sd32768;

	localparam real PI = 3.14159265358979323846;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH         = 3'd0,
		REG_CARRIER_STEP  = 3'd1,
		REG_MOD_STEP      = 3'd2,
		REG_CARRIER_START = 3'd3,
		REG_MOD_START     = 3'd4,
		REG_SAMPLE_COUNT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [PHASE_W-1:0] carrier_step;
		logic [PHASE_W-1:0] mod_step;
		logic [PHASE_W-1:0] carrier_start;
		logic [PHASE_W-1:0] mod_start;
		logic [SC_W-1:0]    sample_count;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic advance;  // move every stage one step
		logic accept;   // an input transfer takes place this cycle
		logic restart;  // reload start phases before this sample
		logic last;     // this sample ends the run, reload afterwards
	} cmd_t;

	// round(32767*cos(2*pi*k/2^addr_bits)), folded to the first octant
	function automatic logic signed [COS_W-1:0] cos_entry(int k, int addr_bits);
		int  m;
		int  kk;
		int  j;
		int  ri;
		bit  neg;
		bit  use_sin;
		real x;
		real v;
		m = 1 << addr_bits;
		kk = k;
		neg = 1'b0;
		if (kk > (m >> 1))
			kk = m - kk;
		if (kk > (m >> 2)) begin
			kk = (m >> 1) - kk;
			neg = 1'b1;
		end
		use_sin = kk > (m >> 3);
		j = use_sin ? ((m >> 2) - kk) : kk;
		x = PI * j * (2.0 ** (1 - addr_bits));
		v = use_sin ? $sin(x) : $cos(x);
		if (v > 1.0)
			v = 1.0;
		ri = int'($floor(32767.0 * v + 0.5));
		return COS_W'(neg ? -ri : ri);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/am_sg_regs.sv =====
// Configuration register file of the AM tone generator.
// Depends on am_sg_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module am_sg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [am_sg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [am_sg_pkg::CFG_DATA_W-1:0] cfg_data,
	output am_sg_pkg::cfg_t                       cfg
);
	import am_sg_pkg::*;

	cfg_t cfg_q;

	// Write one register per transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth         <= DEPTH_RESET;
			cfg_q.carrier_step  <= '0;
			cfg_q.mod_step      <= '0;
			cfg_q.carrier_start <= '0;
			cfg_q.mod_start     <= '0;
			cfg_q.sample_count  <= SAMPLE_COUNT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEPTH:         cfg_q.depth         <= cfg_data[DEPTH_W-1:0];
				REG_CARRIER_STEP:  cfg_q.carrier_step  <= cfg_data[PHASE_W-1:0];
				REG_MOD_STEP:      cfg_q.mod_step      <= cfg_data[PHASE_W-1:0];
				REG_CARRIER_START: cfg_q.carrier_start <= cfg_data[PHASE_W-1:0];
				REG_MOD_START:     cfg_q.mod_start     <= cfg_data[PHASE_W-1:0];
				REG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/am_sg_ctrl.sv =====
// Controller of the AM tone generator: stage valid bits, run counter, last flag.
// Depends on am_sg_pkg; drives the datapath through a cmd_t bundle.
`default_nettype none

module am_sg_ctrl #(
	parameter int COUNT_BITS = am_sg_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          restart,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               last,
	input  wire logic [am_sg_pkg::SC_W-1:0]    sample_count,
	output am_sg_pkg::cmd_t                    cmd
);
	import am_sg_pkg::*;

	// Compare width: holds both 2^COUNT_BITS and the raw count register
	localparam int CW = (COUNT_BITS + 1 > SC_W) ? COUNT_BITS + 1 : SC_W;

	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [COUNT_BITS-1:0] idx_q;

	logic                  advance;
	logic                  accept;
	logic [CW-1:0]         sc_ext;
	logic [CW-1:0]         limit;
	logic [CW-1:0]         count;
	logic [COUNT_BITS-1:0] idx_cur;
	logic [COUNT_BITS:0]   idx_inc;
	logic                  last_c;

	// Whole pipe moves when the output register is empty or being drained
	assign advance  = !v_s3 || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// Effective run length: zero acts as one, clamp to the counter range
	assign sc_ext = CW'(sample_count);
	assign limit  = CW'(1) << COUNT_BITS;
	always_comb begin
		if (sample_count == '0)
			count = CW'(1);
		else if (sc_ext > limit)
			count = limit;
		else
			count = sc_ext;
	end

	// Decide end of run for the sample entering now
	assign idx_cur = restart ? '0 : idx_q;
	assign idx_inc = {1'b0, idx_cur} + (COUNT_BITS + 1)'(1);
	assign last_c  = CW'(idx_inc) >= count;

	// Hold stage valid bits and run index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept)
				idx_q <= last_c ? '0 : idx_inc[COUNT_BITS-1:0];
		end
	end

	// Carry the last flag alongside the samples
	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= last_c;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	assign out_valid   = v_s3;
	assign last        = last_s3;
	assign cmd.advance = advance;
	assign cmd.accept  = accept;
	assign cmd.restart = restart;
	assign cmd.last    = last_c;

endmodule

`default_nettype wire

// ===== rtl/am_sg_dpath.sv =====
// Datapath of the AM tone generator: phase accumulators, cosine ROM, envelope
// and product stages. Depends on am_sg_pkg; driven by am_sg_ctrl commands.
`default_nettype none

module am_sg_dpath #(
	parameter int TABLE_ADDR_BITS = am_sg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire am_sg_pkg::cfg_t                      cfg,
	input  wire am_sg_pkg::cmd_t                      cmd,
	output logic signed [am_sg_pkg::SAMPLE_W-1:0]     sample
);
	import am_sg_pkg::*;

	localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;

	logic [PHASE_W-1:0] cphase_q, mphase_q;
	logic [PHASE_W-1:0] cphase_cur, mphase_cur;
	logic [TABLE_ADDR_BITS-1:0] caddr, maddr;

	logic signed [COS_W-1:0] cos_rom [TABLE_SIZE];

	logic signed [COS_W-1:0]    cc_s1, mc_s1, cc_s2;
	logic signed [17:0]         env_s2;
	logic signed [SAMPLE_W-1:0] smp_s3;

	logic signed [32:0] env_prod;
	logic signed [17:0] env_c;
	logic signed [33:0] out_prod;
	logic signed [17:0] out_shift;
	logic signed [SAMPLE_W-1:0] smp_c;

	// Constant cosine ROM
	for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
		assign cos_rom[gi] = cos_entry(gi, TABLE_ADDR_BITS);
	end

	// Phases used for the sample entering now
	assign cphase_cur = cmd.restart ? cfg.carrier_start : cphase_q;
	assign mphase_cur = cmd.restart ? cfg.mod_start : mphase_q;
	assign caddr = cphase_cur[PHASE_W-1 -: TABLE_ADDR_BITS];
	assign maddr = mphase_cur[PHASE_W-1 -: TABLE_ADDR_BITS];

	// Advance phase accumulators; reload at end of run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cphase_q <= '0;
			mphase_q <= '0;
		end else if (cmd.accept) begin
			if (cmd.last) begin
				cphase_q <= cfg.carrier_start;
				mphase_q <= cfg.mod_start;
			end else begin
				cphase_q <= cphase_cur + cfg.carrier_step;
				mphase_q <= mphase_cur + cfg.mod_step;
			end
		end
	end

	// Envelope: 32768 + floor(depth*modcos / 2^15)
	assign env_prod = $signed({1'b0, cfg.depth}) * mc_s1;
	assign env_c    = 18'sd32768 + 18'(env_prod >>> 15);

	// Sample: floor(env*carcos / 2^16), saturated to +-32768
	assign out_prod  = env_s2 * cc_s2;
	assign out_shift = 18'(out_prod >>> 16);
	always_comb begin
		if (out_shift > 18'sd32768)
			smp_c = SAMPLE_MAX;
		else if (out_shift < -18'sd32768)
			smp_c = SAMPLE_MIN;
		else
			smp_c = SAMPLE_W'(out_shift);
	end

	// Stage registers: ROM read, envelope, output
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			cc_s1  <= cos_rom[caddr];
			mc_s1  <= cos_rom[maddr];
			cc_s2  <= cc_s1;
			env_s2 <= env_c;
			smp_s3 <= smp_c;
		end
	end

	assign sample = smp_s3;

endmodule

`default_nettype wire

// ===== rtl/am_signal_generator_top.sv =====
// AM tone generator, top level: (1 + A*cos(mod phase)) * cos(carrier phase).
// Uses the channel convention below; instantiates am_sg_regs, am_sg_ctrl,
// am_sg_dpath; depends on am_sg_pkg.
//
// Input channel (in_valid/in_ready, field restart): one transfer asks for one
// sample; restart = 1 reloads both start phases and the run index first.
// Output channel (out_valid/out_ready, fields sample in Q2.14 and last): one
// transfer per input transfer, in order; last marks the final sample of a run,
// after which both phases reload from their start registers.
// Configuration: cfg_we writes cfg_data to register cfg_index.
// Pipeline: a sample passes the ROM read, envelope multiply and carrier multiply
// register stages after its input transfer. Throughput: one sample per cycle
// while the output is not stalled, set by the phase accumulator add.
// Stall: while out_valid is high and out_ready low, the pipe holds and
// in_ready is low; in_ready returns in the cycle the result is taken.
// Reset: clears phases, run index, pipe valid bits and loads register defaults.
`default_nettype none

module am_signal_generator_top #(
	parameter int TABLE_ADDR_BITS = am_sg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int COUNT_BITS      = am_sg_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [am_sg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [am_sg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 restart,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [am_sg_pkg::SAMPLE_W-1:0]     sample,
	output logic                                      last
);
	import am_sg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	am_sg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	am_sg_ctrl #(
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.last         (last),
		.sample_count (cfg.sample_count),
		.cmd          (cmd)
	);

	am_sg_dpath #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sample (sample)
	);

endmodule

`default_nettype wire

// ===== rtl/am_sg_checker.sv =====
// Port-level checker for the AM tone generator, bound to the top level.
// Depends on am_sg_pkg for field widths and saturation bounds.
`default_nettype none

module am_sg_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [am_sg_pkg::SAMPLE_W-1:0] sample,
	input wire logic                                 last
);
	import am_sg_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last))
		else $error("result changed while stalled");

	// A blocked output blocks the input side
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// An empty output register never blocks the input side
	a_empty_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// Samples stay within the saturation range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample <= SAMPLE_MAX) && (sample >= SAMPLE_MIN))
		else $error("sample out of range");

endmodule

bind am_signal_generator_top am_sg_checker u_am_sg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.last      (last)
);

`default_nettype wire
